/* hw/rtl/complex_arithmetic_unit_macros.svh */
// Assertion macros shared by the checker.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// Antecedent implies consequent, checked on every rising edge out of reset.
`define CAU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must never hold out of reset.
`define CAU_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* hw/rtl/cau_pkg.sv */
package cau_pkg;

    localparam int DW  = 16;            // operand / result width
    localparam int FB  = 8;             // fraction bits
    localparam int PW  = 2 * DW;        // product width
    localparam int SW  = 2 * DW + 1;    // width of a sum of two products
    localparam int NW  = 3 * DW + FB;   // divider working width
    localparam int LAT = DW + 5;        // start to result strobe, in cycles

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_CMP = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [DW-1:0] D_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] D_MIN = {1'b1, {(DW-1){1'b0}}};

    localparam logic signed [SW-1:0] SUM_MAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [SW-1:0] SUM_MIN = ~SUM_MAX;

    typedef struct packed {
        logic [2:0]           command;
        logic signed [DW-1:0] a_re;
        logic signed [DW-1:0] a_im;
        logic signed [DW-1:0] b_re;
        logic signed [DW-1:0] b_im;
    } t_in;

    typedef struct packed {
        logic signed [DW-1:0] res_re;
        logic signed [DW-1:0] res_im;
        logic                 is_equal;
        logic [1:0]           status;
    } t_out;

    typedef struct packed {
        logic [2:0]           cmd;
        t_out                 fast;
        logic signed [SW-1:0] sum_re;
        logic signed [SW-1:0] sum_im;
        logic [PW-1:0]        den;
    } t_mid;

    typedef struct packed {
        logic [NW-1:0] rem;
        logic [DW-1:0] quo;
        logic          neg;
        logic          sat;
    } t_lane;

    typedef struct packed {
        logic          is_div;
        logic          div_zero;
        t_out          res;
        logic [PW-1:0] den;
        t_lane         re;
        t_lane         im;
    } t_div;

endpackage

/* hw/rtl/cau_front.sv */
module cau_front import cau_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_in  i_item,
    output logic o_vld,
    output t_mid o_mid
);

    // {sat, value} of a DW+1 bit sum clamped to DW bits
    function automatic logic [DW:0] clamp1(input logic signed [DW:0] v);
        logic [DW:0] r;
        if (v > $signed({2'b00, {(DW-1){1'b1}}})) begin
            r = {1'b1, D_MAX};
        end else if (v < $signed({2'b11, {(DW-1){1'b0}}})) begin
            r = {1'b1, D_MIN};
        end else begin
            r = {1'b0, v[DW-1:0]};
        end
        return r;
    endfunction

    logic r_vld1, r_vld2;
    logic [2:0] r_cmd1;
    t_out r_fast1;
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    t_mid r_mid;

    logic signed [DW:0] ar, ai, br, bi;
    logic [DW:0] c_re, c_im;
    t_out n_fast;
    t_mid n_mid;

    assign ar = $signed({i_item.a_re[DW-1], i_item.a_re});
    assign ai = $signed({i_item.a_im[DW-1], i_item.a_im});
    assign br = $signed({i_item.b_re[DW-1], i_item.b_re});
    assign bi = $signed({i_item.b_im[DW-1], i_item.b_im});

    always_comb begin
        n_fast = '0;
        c_re   = '0;
        c_im   = '0;
        case (i_item.command)
            CMD_ADD: begin
                c_re = clamp1(ar + br);
                c_im = clamp1(ai + bi);
            end
            CMD_SUB: begin
                c_re = clamp1(ar - br);
                c_im = clamp1(ai - bi);
            end
            default: begin
            end
        endcase
        n_fast.res_re   = c_re[DW-1:0];
        n_fast.res_im   = c_im[DW-1:0];
        n_fast.status   = (c_re[DW] | c_im[DW]) ? ST_SAT : ST_OK;
        n_fast.is_equal = (i_item.command == CMD_CMP) &&
                          (i_item.a_re == i_item.b_re) && (i_item.a_im == i_item.b_im);
    end

    always_comb begin
        n_mid.cmd  = r_cmd1;
        n_mid.fast = r_fast1;
        n_mid.den  = r_p4 + r_p5;
        if (r_cmd1 == CMD_MUL) begin
            n_mid.sum_re = SW'(r_p0) - SW'(r_p1);
            n_mid.sum_im = SW'(r_p2) + SW'(r_p3);
        end else begin
            n_mid.sum_re = SW'(r_p0) + SW'(r_p1);
            n_mid.sum_im = SW'(r_p3) - SW'(r_p2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd1  <= i_item.command;
        r_fast1 <= n_fast;
        r_p0    <= i_item.a_re * i_item.b_re;
        r_p1    <= i_item.a_im * i_item.b_im;
        r_p2    <= i_item.a_re * i_item.b_im;
        r_p3    <= i_item.a_im * i_item.b_re;
        r_p4    <= i_item.b_re * i_item.b_re;
        r_p5    <= i_item.b_im * i_item.b_im;
        r_mid   <= n_mid;
    end

    assign o_vld = r_vld2;
    assign o_mid = r_mid;

endmodule

/* hw/rtl/cau_norm.sv */
module cau_norm import cau_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_mid i_mid,
    output logic o_vld,
    output t_div o_div
);

    // {sat, value}: floor shift of a product sum, clamped
    function automatic logic [DW:0] mul_part(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] sh;
        logic [DW:0] r;
        sh = s >>> FB;
        if (sh > SUM_MAX) begin
            r = {1'b1, D_MAX};
        end else if (sh < SUM_MIN) begin
            r = {1'b1, D_MIN};
        end else begin
            r = {1'b0, sh[DW-1:0]};
        end
        return r;
    endfunction

    logic r_vld3, r_vld4;
    t_div r_d3, r_d4;
    t_div n_d3, n_d4;
    logic [DW:0] m_re, m_im;
    logic [SW-1:0] mag_re, mag_im;
    logic [NW-1:0] thr, thr_neg, rs_re, rs_im;

    always_comb begin
        m_re   = mul_part(i_mid.sum_re);
        m_im   = mul_part(i_mid.sum_im);
        mag_re = i_mid.sum_re[SW-1] ? -i_mid.sum_re : i_mid.sum_re;
        mag_im = i_mid.sum_im[SW-1] ? -i_mid.sum_im : i_mid.sum_im;

        n_d3          = '0;
        n_d3.is_div   = (i_mid.cmd == CMD_DIV);
        n_d3.div_zero = (i_mid.den == '0);
        n_d3.den      = i_mid.den;
        n_d3.re.rem   = NW'(mag_re);
        n_d3.re.neg   = i_mid.sum_re[SW-1];
        n_d3.im.rem   = NW'(mag_im);
        n_d3.im.neg   = i_mid.sum_im[SW-1];
        if (i_mid.cmd == CMD_MUL) begin
            n_d3.res.res_re = m_re[DW-1:0];
            n_d3.res.res_im = m_im[DW-1:0];
            n_d3.res.status = (m_re[DW] | m_im[DW]) ? ST_SAT : ST_OK;
        end else begin
            n_d3.res = i_mid.fast;
        end
    end

    // overflow check: quotient > limit iff numerator >= (limit + 1) * den
    always_comb begin
        thr     = NW'(r_d3.den) << (DW - 1);
        thr_neg = thr + NW'(r_d3.den);
        rs_re   = r_d3.re.rem << FB;
        rs_im   = r_d3.im.rem << FB;
        n_d4        = r_d3;
        n_d4.re.rem = rs_re;
        n_d4.im.rem = rs_im;
        n_d4.re.sat = rs_re >= (r_d3.re.neg ? thr_neg : thr);
        n_d4.im.sat = rs_im >= (r_d3.im.neg ? thr_neg : thr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            r_vld3 <= i_vld;
            r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d3 <= n_d3;
        r_d4 <= n_d4;
    end

    assign o_vld = r_vld4;
    assign o_div = r_d4;

endmodule

/* hw/rtl/cau_div_stage.sv */
module cau_div_stage import cau_pkg::*; #(
    parameter int BIT = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_div i_div,
    output logic o_vld,
    output t_div o_div
);

    // one restoring step per lane: quotient bit BIT
    logic r_vld;
    t_div r_div, n_div;
    logic [NW-1:0] thr;

    always_comb begin
        thr   = NW'(i_div.den) << BIT;
        n_div = i_div;
        if (i_div.re.rem >= thr) begin
            n_div.re.rem      = i_div.re.rem - thr;
            n_div.re.quo[BIT] = 1'b1;
        end
        if (i_div.im.rem >= thr) begin
            n_div.im.rem      = i_div.im.rem - thr;
            n_div.im.quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div <= n_div;
    end

    assign o_vld = r_vld;
    assign o_div = r_div;

endmodule

/* hw/rtl/complex_arithmetic_unit.sv */
// Complex arithmetic unit, signed Q8.8 operands and results.
//
// Command channel: an item (command, a, b) transfers on a rising edge with
// i_start high and o_busy low. o_busy is never raised, so one item can
// transfer on every cycle.
// Result channel: o_valid strobes for one cycle with the result in o_result;
// the receiver cannot stall, so results leave exactly as they come out.
//
// Every command passes through the same pipeline stages:
//   1 multiply (four cross products, |b|^2 terms, add/sub/compare)
//   2 product sums and |b|^2
//   3 multiply rounding/clamp, sign-magnitude of the divide numerators
//   4 divide overflow check and numerator scaling
//   DW restoring divider steps, one quotient bit each
//   1 output formatting register
// Throughput is one item per cycle; the divider chain sets the depth.
// Reset (synchronous, active low) clears every valid bit in the pipe; items
// in flight are dropped and no result strobes until new items arrive.
module complex_arithmetic_unit import cau_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    input  t_in  i_item,
    output logic o_valid,
    output t_out o_result
);

    logic f_vld, n_vld;
    t_mid f_mid;
    t_div n_div;

    logic [DW:0] d_vld;
    t_div        d_div [DW+1];

    logic r_valid;
    t_out r_result, n_result;
    t_lane lre, lim;

    assign o_busy = 1'b0;

    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_start),
        .i_item  (i_item),
        .o_vld   (f_vld),
        .o_mid   (f_mid)
    );

    cau_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (f_vld),
        .i_mid   (f_mid),
        .o_vld   (n_vld),
        .o_div   (n_div)
    );

    assign d_vld[0] = n_vld;
    assign d_div[0] = n_div;

    // quotient bits MSB first
    for (genvar g = 0; g < DW; g++) begin : g_div
        cau_div_stage #(.BIT(DW - 1 - g)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (d_vld[g]),
            .i_div   (d_div[g]),
            .o_vld   (d_vld[g+1]),
            .o_div   (d_div[g+1])
        );
    end

    // final formatting: divide results get sign, clamp and status here
    always_comb begin
        lre = d_div[DW].re;
        lim = d_div[DW].im;
        n_result = d_div[DW].res;
        if (d_div[DW].is_div) begin
            n_result = '0;
            if (d_div[DW].div_zero) begin
                n_result.status = ST_DIVZ;
            end else begin
                if (lre.sat) begin
                    n_result.res_re = lre.neg ? D_MIN : D_MAX;
                end else begin
                    n_result.res_re = lre.neg ? -lre.quo : lre.quo;
                end
                if (lim.sat) begin
                    n_result.res_im = lim.neg ? D_MIN : D_MAX;
                end else begin
                    n_result.res_im = lim.neg ? -lim.quo : lim.quo;
                end
                n_result.status = (lre.sat | lim.sat) ? ST_SAT : ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= d_vld[DW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* hw/rtl/cau_checker.sv */
`include "complex_arithmetic_unit_macros.svh"

module cau_props import cau_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid,
    input t_out o_result
);

    `CAU_ASSERT_IMP(a_latency, i_clk, i_rst_n, i_start && !o_busy, ##LAT o_valid, "result missing at fixed latency")
    `CAU_ASSERT_IMP(a_no_extra, i_clk, i_rst_n, !(i_start && !o_busy), ##LAT !o_valid, "result without a transfer")
    `CAU_ASSERT_NEVER(a_status, i_clk, i_rst_n, o_valid && (o_result.status != ST_OK) && (o_result.status != ST_DIVZ) && (o_result.status != ST_SAT), "undefined status code")
    `CAU_ASSERT_IMP(a_divz_zero, i_clk, i_rst_n, o_valid && (o_result.status == ST_DIVZ), (o_result.res_re == '0) && (o_result.res_im == '0) && !o_result.is_equal, "divide by zero with nonzero result")

endmodule

bind complex_arithmetic_unit cau_props u_cau_checker (.*);

/* test/cau_checker.sv */
`timescale 1ns / 1ps

module cau_checker import cau_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_in  i_item,
    input  logic i_valid,
    input  t_out i_result,
    output int   o_errors,
    output int   o_pending
);

    localparam longint VMAX = (64'sd1 <<< (DW - 1)) - 1;
    localparam longint VMIN = -VMAX - 1;

    t_out expected_results[$];

    function automatic longint clamp_part(longint v, inout bit sat);
        if (v > VMAX) begin
            sat = 1;
            return VMAX;
        end
        if (v < VMIN) begin
            sat = 1;
            return VMIN;
        end
        return v;
    endfunction

    // floor of the sum over 2^FB; sums stay well inside 64 bits at DW = 16
    function automatic longint scale_product(longint s, inout bit sat);
        return clamp_part(s >>> FB, sat);
    endfunction

    function automatic longint divide_part(longint num, longint den, inout bit sat);
        longint q;
        q = (num <<< FB) / den;   // SV integer division truncates toward zero
        return clamp_part(q, sat);
    endfunction

    function automatic t_out predict_result(t_in it);
        t_out   r;
        longint ar, ai, br, bi, den;
        bit     sat;
        ar = longint'(it.a_re);
        ai = longint'(it.a_im);
        br = longint'(it.b_re);
        bi = longint'(it.b_im);
        sat = 0;
        r = '0;
        case (it.command)
            CMD_ADD: begin
                r.res_re = DW'(clamp_part(ar + br, sat));
                r.res_im = DW'(clamp_part(ai + bi, sat));
            end
            CMD_SUB: begin
                r.res_re = DW'(clamp_part(ar - br, sat));
                r.res_im = DW'(clamp_part(ai - bi, sat));
            end
            CMD_MUL: begin
                r.res_re = DW'(scale_product(ar * br - ai * bi, sat));
                r.res_im = DW'(scale_product(ar * bi + ai * br, sat));
            end
            CMD_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.status = ST_DIVZ;
                end else begin
                    r.res_re = DW'(divide_part(ar * br + ai * bi, den, sat));
                    r.res_im = DW'(divide_part(ai * br - ar * bi, den, sat));
                end
            end
            CMD_CMP: r.is_equal = (ar == br) && (ai == bi);
            default: ;
        endcase
        if (sat) r.status = ST_SAT;
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_out exp_r;
        if (!i_rst_n) begin
            expected_results.delete();
            o_errors <= 0;
        end else begin
            if (i_valid) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result expected none actual %h", $time, i_result);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r !== i_result) begin
                        $display("%0t: result mismatch expected re=%h im=%h eq=%b st=%0d actual re=%h im=%h eq=%b st=%0d",
                                 $time, exp_r.res_re, exp_r.res_im, exp_r.is_equal,
                                 exp_r.status, i_result.res_re, i_result.res_im,
                                 i_result.is_equal, i_result.status);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_start && !i_busy) expected_results.push_back(predict_result(i_item));
        end
    end

endmodule

/* test/tb_complex_arithmetic_unit.sv */
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit;
    import cau_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_start = 0;
    t_in  i_item = '0;
    logic o_busy;
    logic o_valid;
    t_out o_result;
    int   errors;
    int   pending;

    always #5 i_clk = ~i_clk;

    complex_arithmetic_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    cau_checker checker_i (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_busy   (o_busy),
        .i_item   (i_item),
        .i_valid  (o_valid),
        .i_result (o_result),
        .o_errors (errors),
        .o_pending(pending)
    );

    // Operand mix: extremes, zero, small values near zero, and full random.
    function automatic logic [DW-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return D_MAX;
            1: return D_MIN;
            2: return '0;
            3: return DW'($signed($urandom_range(0, 1024)) - 512);
            4: return DW'($signed($urandom_range(0, 64)) - 32);
            default: return DW'($urandom);
        endcase
    endfunction

    // Hold one item until it transfers; optional random gap afterward.
    task automatic send_item(input t_in it, input bit allow_gap);
        int gap;
        i_item <= it;
        i_start <= 1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        if (allow_gap && $urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                               : $urandom_range(1, 3);
            i_start <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_fields(input logic [2:0] c, input logic [DW-1:0] ar,
                               input logic [DW-1:0] ai, input logic [DW-1:0] br,
                               input logic [DW-1:0] bi);
        t_in it;
        it.command = c;
        it.a_re = ar;
        it.a_im = ai;
        it.b_re = br;
        it.b_im = bi;
        send_item(it, 0);
    endtask

    initial begin
        t_in it;
        int  wait_cycles;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: every command at the extremes, divide by zero, equality
        send_fields(CMD_ADD, D_MAX, D_MIN, D_MAX, D_MIN);
        send_fields(CMD_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0001);
        send_fields(CMD_SUB, D_MIN, D_MAX, D_MAX, D_MIN);
        send_fields(CMD_SUB, 16'h1234, 16'h0001, 16'h0234, 16'h0002);
        send_fields(CMD_MUL, D_MIN, D_MIN, D_MIN, D_MIN);
        send_fields(CMD_MUL, D_MAX, D_MIN, D_MAX, D_MAX);
        send_fields(CMD_MUL, 16'h0100, 16'h0100, 16'h0200, 16'hff80);
        send_fields(CMD_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
        send_fields(CMD_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000);
        send_fields(CMD_DIV, D_MAX, D_MAX, 16'h0000, 16'h0000);
        send_fields(CMD_DIV, D_MAX, D_MIN, 16'h0001, 16'h0000);
        send_fields(CMD_DIV, D_MIN, D_MIN, 16'h0000, 16'hffff);
        send_fields(CMD_DIV, 16'h0300, 16'hfd00, 16'h0100, 16'h0100);
        send_fields(CMD_DIV, 16'hffff, 16'h0001, D_MIN, D_MIN);
        send_fields(CMD_DIV, 16'h0001, 16'h0000, 16'h0003, 16'h0000);
        send_fields(CMD_CMP, D_MIN, D_MAX, D_MIN, D_MAX);
        send_fields(CMD_CMP, 16'h0001, 16'h0002, 16'h0001, 16'h0003);
        send_fields(CMD_CMP, 16'h0005, 16'h0002, 16'h0004, 16'h0002);
        send_fields(3'd5, D_MAX, D_MAX, D_MAX, D_MAX);
        send_fields(3'd6, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
        send_fields(3'd7, D_MIN, D_MIN, 16'h0000, 16'h0000);

        for (int n = 0; n < 1700; n++) begin
            it.command = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                      : 3'($urandom_range(0, 4));
            it.a_re = pick_operand();
            it.a_im = pick_operand();
            it.b_re = pick_operand();
            it.b_im = pick_operand();
            // equal operands and zero divisors come up often enough to matter
            if (it.command == CMD_CMP && $urandom_range(0, 1)) begin
                it.b_re = it.a_re;
                it.b_im = it.a_im;
                if ($urandom_range(0, 2) == 0) it.b_im[$urandom_range(0, DW-1)] ^= 1'b1;
            end
            if (it.command == CMD_DIV && $urandom_range(0, 9) == 0) begin
                it.b_re = '0;
                it.b_im = '0;
            end
            send_item(it, (n % 400) < 300);
        end
        i_start <= 0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 2000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (LAT + 10) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // timeout
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
